// File: rtl/core/gdc_pkg.sv
// Shared types and constants for the gated detection confirmer.
// Holds the report, record, configuration and result structures and the codes.
// Depends on nothing; every other file of the block refers to it by scoped names.
package gdc_pkg;

  localparam int CFG_DATA_W = 20;

  localparam logic [1:0] CFG_CONFIRM_COUNT = 2'd0;
  localparam logic [1:0] CFG_MATCH_RADIUS  = 2'd1;
  localparam logic [1:0] CFG_MAX_TIME_GAP  = 2'd2;

  localparam logic [7:0]  CONFIRM_COUNT_RESET = 8'd3;
  localparam logic [19:0] MATCH_RADIUS_RESET  = 20'd461;
  localparam logic [15:0] MAX_TIME_GAP_RESET  = 16'd800;

  localparam logic [7:0]  CONFIRM_COUNT_FLOOR = 8'd1;
  localparam logic [19:0] MATCH_RADIUS_FLOOR  = 20'd10;
  localparam logic [15:0] MAX_TIME_GAP_FLOOR  = 16'd50;

  localparam logic [7:0] HITS_MAX = 8'hFF;

  typedef enum logic [1:0] {
    OUT_IGNORED   = 2'd0,
    OUT_COUNTING  = 2'd1,
    OUT_CONFIRMED = 2'd2
  } outcome_t;

  typedef struct packed {
    logic [7:0]  confirm_count;
    logic [19:0] match_radius;
    logic [15:0] max_time_gap;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         cls;
    logic [15:0]        id;
    logic [7:0]         reported_hits;
    logic               hits_given;
    logic               confirmed_flag;
    logic               confirmed_given;
    logic [31:0]        time_ms;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
  } report_t;

  typedef struct packed {
    logic [15:0]        id;
    logic [7:0]         hits;
    logic [31:0]        time_ms;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
  } rec_data_t;

  typedef struct packed {
    logic      valid;
    logic      done;
    rec_data_t data;
  } record_t;

  typedef struct packed {
    logic      we;
    logic      done_set;
    rec_data_t data;
  } rec_update_t;

  typedef struct packed {
    outcome_t           outcome;
    logic               candidate_event;
    logic [1:0]         cls;
    logic [7:0]         hit_total;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic [31:0]        time_ms;
  } result_t;

endpackage

// File: rtl/core/gdc_eval.sv
// Combinational evaluation of one detection report against its class record.
// Gates on id, time gap and squared distance and forms the record update.
// Depends on gdc_pkg for the report, record, configuration and result types.
module gdc_eval (
  input  gdc_pkg::report_t     rpt,
  input  gdc_pkg::record_t     rec,
  input  logic                 in_range,
  input  gdc_pkg::cfg_t        cfg,
  output gdc_pkg::result_t     res,
  output gdc_pkg::rec_update_t upd
);

  logic [7:0]         cc;
  logic [19:0]        rad;
  logic [15:0]        gap;
  logic [7:0]         eff_hits;
  logic               confirmed;
  logic [31:0]        dt;
  logic signed [24:0] dx;
  logic signed [24:0] dy;
  logic signed [24:0] dz;
  logic signed [49:0] sqx;
  logic signed [49:0] sqy;
  logic signed [49:0] sqz;
  logic [49:0]        d2;
  logic [39:0]        rad_sq;
  logic               id_ok;
  logic               same;
  logic [7:0]         h_base;
  logic [7:0]         h_inc;
  logic [7:0]         h;

  assign cc  = (cfg.confirm_count < gdc_pkg::CONFIRM_COUNT_FLOOR) ?
               gdc_pkg::CONFIRM_COUNT_FLOOR : cfg.confirm_count;
  assign rad = (cfg.match_radius < gdc_pkg::MATCH_RADIUS_FLOOR) ?
               gdc_pkg::MATCH_RADIUS_FLOOR : cfg.match_radius;
  assign gap = (cfg.max_time_gap < gdc_pkg::MAX_TIME_GAP_FLOOR) ?
               gdc_pkg::MAX_TIME_GAP_FLOOR : cfg.max_time_gap;

  assign eff_hits  = rpt.hits_given ? rpt.reported_hits : cc;
  assign confirmed = rpt.confirmed_given ? rpt.confirmed_flag : (eff_hits >= cc);

  assign dt = (rpt.time_ms >= rec.data.time_ms) ? (rpt.time_ms - rec.data.time_ms)
                                                : (rec.data.time_ms - rpt.time_ms);

  assign dx = {rpt.x[23], rpt.x} - {rec.data.x[23], rec.data.x};
  assign dy = {rpt.y[23], rpt.y} - {rec.data.y[23], rec.data.y};
  assign dz = {rpt.z[23], rpt.z} - {rec.data.z[23], rec.data.z};

  assign sqx = dx * dx;
  assign sqy = dy * dy;
  assign sqz = dz * dz;

  assign d2     = $unsigned(sqx) + $unsigned(sqy) + $unsigned(sqz);
  assign rad_sq = {20'd0, rad} * {20'd0, rad};

  assign id_ok = (rpt.id == 16'd0) || (rec.data.id == 16'd0) || (rpt.id == rec.data.id);
  assign same  = rec.valid && id_ok && (dt <= {16'd0, gap}) && (d2 <= {10'd0, rad_sq});

  assign h_base = same ? rec.data.hits : 8'd0;
  assign h_inc  = (h_base == gdc_pkg::HITS_MAX) ? gdc_pkg::HITS_MAX : h_base + 8'd1;
  assign h      = (eff_hits > h_inc) ? eff_hits : h_inc;

  always_comb begin
    res.cls     = rpt.cls;
    res.x       = rpt.x;
    res.y       = rpt.y;
    res.z       = rpt.z;
    res.time_ms = rpt.time_ms;

    upd.data.id      = rpt.id;
    upd.data.hits    = h;
    upd.data.time_ms = rpt.time_ms;
    upd.data.x       = rpt.x;
    upd.data.y       = rpt.y;
    upd.data.z       = rpt.z;

    if (!in_range) begin
      res.outcome         = gdc_pkg::OUT_IGNORED;
      res.candidate_event = 1'b0;
      res.hit_total       = 8'd0;
      upd.we              = 1'b0;
      upd.done_set        = 1'b0;
    end else if (rec.done) begin
      res.outcome         = gdc_pkg::OUT_IGNORED;
      res.candidate_event = 1'b0;
      res.hit_total       = rec.data.hits;
      upd.we              = 1'b0;
      upd.done_set        = 1'b0;
    end else begin
      res.outcome         = (h >= cc) ? gdc_pkg::OUT_CONFIRMED : gdc_pkg::OUT_COUNTING;
      res.candidate_event = !confirmed;
      res.hit_total       = h;
      upd.we              = 1'b1;
      upd.done_set        = (h >= cc);
    end
  end

endmodule

// File: rtl/core/gated_detection_confirmer.sv
// Top level of the gated detection confirmer: input register, per-class records,
// result register and the configuration registers.
// Depends on gdc_pkg and instantiates gdc_eval.
//
// Use: each word on the input channel is one detection report. It is taken when
// in_valid is high and in_stall is low, and yields exactly one result word on the
// output channel, taken when out_valid is high and out_stall is low.
// Reports pass the input register, then the result register. One report is
// accepted every cycle while in_stall is low: it is evaluated against its class
// record in the cycle after it is registered, and the record is rewritten at the
// same edge that loads the result register; a later report of that class sees it.
// When the receiver stalls, the result register holds its word, the input
// register takes one more report, and in_stall then rises until the result moves.
// The configuration channel is always ready; registers should be written only
// while no report is in flight. Synchronous reset restores the register defaults
// and clears every candidate and confirmed mark at once; no clearing pass follows.
module gated_detection_confirmer #(
  parameter int NUM_CLASSES = 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    target_class,
  input  logic [15:0]                   source_id,
  input  logic [7:0]                    reported_hits,
  input  logic                          hits_given,
  input  logic                          confirmed_flag,
  input  logic                          confirmed_given,
  input  logic [31:0]                   time_ms,
  input  logic signed [23:0]            pos_x,
  input  logic signed [23:0]            pos_y,
  input  logic signed [23:0]            pos_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    outcome,
  output logic                          candidate_event,
  output logic [1:0]                    out_class,
  output logic [7:0]                    hit_total,
  output logic signed [23:0]            out_x,
  output logic signed [23:0]            out_y,
  output logic signed [23:0]            out_z,
  output logic [31:0]                   out_time,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [gdc_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  gdc_pkg::cfg_t        cfg;
  gdc_pkg::report_t     s1;
  logic                 s1_valid;
  logic                 s1_adv;
  logic                 in_accept;
  logic                 s1_in_range;
  logic [IDX_W-1:0]     s1_idx;
  logic [NUM_CLASSES-1:0] cand_valid;
  logic [NUM_CLASSES-1:0] class_done;
  gdc_pkg::rec_data_t   rec_data [NUM_CLASSES];
  gdc_pkg::record_t     rec_sel;
  gdc_pkg::result_t     res;
  gdc_pkg::rec_update_t upd;
  gdc_pkg::result_t     out_reg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.confirm_count <= gdc_pkg::CONFIRM_COUNT_RESET;
      cfg.match_radius  <= gdc_pkg::MATCH_RADIUS_RESET;
      cfg.max_time_gap  <= gdc_pkg::MAX_TIME_GAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gdc_pkg::CFG_CONFIRM_COUNT: cfg.confirm_count <= cfg_data[7:0];
        gdc_pkg::CFG_MATCH_RADIUS:  cfg.match_radius  <= cfg_data[19:0];
        gdc_pkg::CFG_MAX_TIME_GAP:  cfg.max_time_gap  <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  assign s1_adv    = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1.cls             <= target_class;
      s1.id              <= source_id;
      s1.reported_hits   <= reported_hits;
      s1.hits_given      <= hits_given;
      s1.confirmed_flag  <= confirmed_flag;
      s1.confirmed_given <= confirmed_given;
      s1.time_ms         <= time_ms;
      s1.x               <= pos_x;
      s1.y               <= pos_y;
      s1.z               <= pos_z;
    end
  end

  assign s1_in_range = 32'(s1.cls) < 32'(NUM_CLASSES);
  assign s1_idx      = s1_in_range ? IDX_W'(s1.cls) : '0;

  assign rec_sel.valid = cand_valid[s1_idx];
  assign rec_sel.done  = class_done[s1_idx];
  assign rec_sel.data  = rec_data[s1_idx];

  gdc_eval u_eval (
    .rpt      (s1),
    .rec      (rec_sel),
    .in_range (s1_in_range),
    .cfg      (cfg),
    .res      (res),
    .upd      (upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_valid <= '0;
      class_done <= '0;
    end else if (s1_adv && upd.we) begin
      cand_valid[s1_idx] <= 1'b1;
      if (upd.done_set) begin
        class_done[s1_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && upd.we) begin
      rec_data[s1_idx] <= upd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_reg <= res;
    end
  end

  assign outcome         = out_reg.outcome;
  assign candidate_event = out_reg.candidate_event;
  assign out_class       = out_reg.cls;
  assign hit_total       = out_reg.hit_total;
  assign out_x           = out_reg.x;
  assign out_y           = out_reg.y;
  assign out_z           = out_reg.z;
  assign out_time        = out_reg.time_ms;

  a_stall_needs_held_word : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid))
    else $error("input stalled without a held word in both registers");

  a_confirm_latches : assert property (@(posedge clk) disable iff (rst)
    (s1_adv && res.outcome == gdc_pkg::OUT_CONFIRMED) |=> class_done[$past(s1_idx)])
    else $error("confirmed class was not latched done");

  a_done_is_ignored : assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_in_range && class_done[s1_idx]) |->
      (res.outcome == gdc_pkg::OUT_IGNORED && !upd.we))
    else $error("report for a confirmed class was not ignored");

  a_candidate_counted : assert property (@(posedge clk) disable iff (rst)
    (out_valid && candidate_event) |-> (outcome != gdc_pkg::OUT_IGNORED))
    else $error("candidate raised on an ignored report");

endmodule
